[rtl/fisa_pkg.sv]
// ----------------------------------------------------------------------------
// fisa_pkg
// Request and response types, action and status codes, and the helper that
// derives the used count for the free-index stack allocator.
// ----------------------------------------------------------------------------
package fisa_pkg;

    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_CLEAR   = 2'd2;
    localparam logic [1:0] ACT_REBUILD = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [10:0] POOL_RESET = 11'd1024;
    localparam logic [10:0] COUNT_MAX  = 11'h7FF;

    typedef struct packed {
        logic [1:0] action;
        logic [9:0] release_index;
    } t_req;

    typedef struct packed {
        logic [9:0]  granted_index;
        logic [1:0]  status;
        logic        list_empty;
        logic [10:0] used_count;
    } t_rsp;

    function automatic logic [10:0] used_of(input logic [10:0] size,
                                            input logic [10:0] free);
        used_of = (size > free) ? (size - free) : 11'd0;
    endfunction

endpackage

[rtl/fisa_ram.sv]
// ----------------------------------------------------------------------------
// fisa_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module fisa_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/fisa_ctrl.sv]
// ----------------------------------------------------------------------------
// fisa_ctrl
// Sequencer for the free-index stack: keeps the head and free count, drives
// the next-link memory for pop, push and the rebuild sweep, and registers
// the response.
// ----------------------------------------------------------------------------
module fisa_ctrl #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  fisa_pkg::t_req                 i_req,
    input  logic [10:0]                    i_eff_size,
    output logic                           o_valid,
    output fisa_pkg::t_rsp                 o_rsp,
    output logic                           o_mem_we,
    output logic [$clog2(MAX_ENTRIES)-1:0] o_mem_waddr,
    output logic [$clog2(MAX_ENTRIES)-1:0] o_mem_wdata_idx,
    output logic                           o_mem_wdata_none,
    output logic [$clog2(MAX_ENTRIES)-1:0] o_mem_raddr,
    input  logic [$clog2(MAX_ENTRIES)-1:0] i_mem_rdata_idx,
    input  logic                           i_mem_rdata_none
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam logic [10:0] RST_SIZE =
        (32'(fisa_pkg::POOL_RESET) > MAX_ENTRIES) ? 11'(MAX_ENTRIES) : fisa_pkg::POOL_RESET;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ALLOC = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;

    logic [1:0]     r_state,   n_state;
    logic [IW-1:0]  r_top,     n_top;
    logic           r_none,    n_none;
    logic [10:0]    r_free,    n_free;
    logic [IW-1:0]  r_ptr,     n_ptr;
    logic [10:0]    r_sweep_n, n_sweep_n;
    logic           r_report,  n_report;
    logic           r_valid,   n_valid;
    fisa_pkg::t_rsp r_rsp,     n_rsp;

    logic accept;
    logic sweep_last;
    logic [10:0] free_inc;
    logic [10:0] free_dec;

    assign accept     = i_start && (r_state == S_IDLE);
    assign sweep_last = (32'(r_ptr) + 32'd1) >= 32'(r_sweep_n);
    assign free_inc   = (r_free < fisa_pkg::COUNT_MAX) ? (r_free + 11'd1) : r_free;
    assign free_dec   = (r_free > 11'd0) ? (r_free - 11'd1) : r_free;

    always_comb begin
        n_state   = r_state;
        n_top     = r_top;
        n_none    = r_none;
        n_free    = r_free;
        n_ptr     = r_ptr;
        n_sweep_n = r_sweep_n;
        n_report  = r_report;
        n_valid   = 1'b0;
        n_rsp     = r_rsp;

        o_mem_we         = 1'b0;
        o_mem_waddr      = r_ptr;
        o_mem_wdata_idx  = r_top;
        o_mem_wdata_none = r_none;
        o_mem_raddr      = r_top;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_rsp.granted_index = 10'd0;
                    n_rsp.status        = fisa_pkg::ST_OK;
                    unique case (i_req.action)
                        fisa_pkg::ACT_ALLOC: begin
                            if (r_none) begin
                                n_valid             = 1'b1;
                                n_rsp.status        = fisa_pkg::ST_EMPTY;
                                n_rsp.list_empty    = 1'b1;
                                n_rsp.used_count    = fisa_pkg::used_of(i_eff_size, r_free);
                            end else begin
                                n_state = S_ALLOC;
                            end
                        end
                        fisa_pkg::ACT_RELEASE: begin
                            n_valid = 1'b1;
                            if ({1'b0, i_req.release_index} >= i_eff_size) begin
                                n_rsp.status     = fisa_pkg::ST_RANGE;
                                n_rsp.list_empty = r_none;
                                n_rsp.used_count = fisa_pkg::used_of(i_eff_size, r_free);
                            end else begin
                                o_mem_we         = 1'b1;
                                o_mem_waddr      = IW'(i_req.release_index);
                                n_top            = IW'(i_req.release_index);
                                n_none           = 1'b0;
                                n_free           = free_inc;
                                n_rsp.list_empty = 1'b0;
                                n_rsp.used_count = fisa_pkg::used_of(i_eff_size, free_inc);
                            end
                        end
                        fisa_pkg::ACT_CLEAR: begin
                            n_valid          = 1'b1;
                            n_none           = 1'b1;
                            n_free           = 11'd0;
                            n_rsp.list_empty = 1'b1;
                            n_rsp.used_count = i_eff_size;
                        end
                        fisa_pkg::ACT_REBUILD: begin
                            n_top     = '0;
                            n_none    = (i_eff_size == 11'd0);
                            n_free    = i_eff_size;
                            n_ptr     = '0;
                            n_sweep_n = i_eff_size;
                            if (i_eff_size == 11'd0) begin
                                n_valid          = 1'b1;
                                n_rsp.list_empty = 1'b1;
                                n_rsp.used_count = 11'd0;
                            end else begin
                                n_report = 1'b1;
                                n_state  = S_SWEEP;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                n_valid             = 1'b1;
                n_top               = i_mem_rdata_idx;
                n_none              = i_mem_rdata_none;
                n_free              = free_dec;
                n_rsp.granted_index = 10'(r_top);
                n_rsp.status        = fisa_pkg::ST_OK;
                n_rsp.list_empty    = i_mem_rdata_none;
                n_rsp.used_count    = fisa_pkg::used_of(i_eff_size, free_dec);
                n_state             = S_IDLE;
            end
            S_SWEEP: begin
                o_mem_we         = 1'b1;
                o_mem_waddr      = r_ptr;
                o_mem_wdata_idx  = sweep_last ? '0 : (r_ptr + IW'(1));
                o_mem_wdata_none = sweep_last;
                n_ptr            = r_ptr + IW'(1);
                if (sweep_last) begin
                    n_state = S_IDLE;
                    if (r_report) begin
                        n_valid             = 1'b1;
                        n_rsp.granted_index = 10'd0;
                        n_rsp.status        = fisa_pkg::ST_OK;
                        n_rsp.list_empty    = r_none;
                        n_rsp.used_count    = fisa_pkg::used_of(i_eff_size, r_free);
                    end
                    n_report = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_SWEEP;
            r_top     <= '0;
            r_none    <= 1'b0;
            r_free    <= RST_SIZE;
            r_ptr     <= '0;
            r_sweep_n <= RST_SIZE;
            r_report  <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_top     <= n_top;
            r_none    <= n_none;
            r_free    <= n_free;
            r_ptr     <= n_ptr;
            r_sweep_n <= n_sweep_n;
            r_report  <= n_report;
            r_valid   <= n_valid;
        end
        r_rsp <= n_rsp;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

[rtl/free_index_stack_allocator.sv]
// ----------------------------------------------------------------------------
// free_index_stack_allocator
// Free list of entry indices held as a linked stack in a next-link RAM.
// Allocate: the ALLOC state pops the head from the registered RAM read and
// keeps busy high, so the next request waits. Release and clear: response the
// cycle after accept, one request per cycle. Rebuild: sweeps min(pool_size,
// MAX_ENTRIES) entries, one entry per cycle, busy high, then responds. Reset
// runs this sweep over min(1024, MAX_ENTRIES) entries, busy high, no response.
// ----------------------------------------------------------------------------
module free_index_stack_allocator #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  fisa_pkg::t_req i_req,
    output logic           o_valid,
    output fisa_pkg::t_rsp o_rsp,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [10:0]    i_cfg_data
);

    localparam int IW = $clog2(MAX_ENTRIES);

    logic [10:0]   r_pool;
    logic [10:0]   eff_size;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [IW-1:0] mem_wdata_idx;
    logic          mem_wdata_none;
    logic [IW-1:0] mem_raddr;
    logic [IW:0]   mem_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool <= fisa_pkg::POOL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_pool <= i_cfg_data;
        end
    end

    assign eff_size = (32'(r_pool) > MAX_ENTRIES) ? 11'(MAX_ENTRIES) : r_pool;

    fisa_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .o_busy           (busy),
        .i_req            (i_req),
        .i_eff_size       (eff_size),
        .o_valid          (o_valid),
        .o_rsp            (o_rsp),
        .o_mem_we         (mem_we),
        .o_mem_waddr      (mem_waddr),
        .o_mem_wdata_idx  (mem_wdata_idx),
        .o_mem_wdata_none (mem_wdata_none),
        .o_mem_raddr      (mem_raddr),
        .i_mem_rdata_idx  (mem_rdata[IW-1:0]),
        .i_mem_rdata_none (mem_rdata[IW])
    );

    fisa_ram #(
        .WIDTH (IW + 1),
        .DEPTH (MAX_ENTRIES)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata ({mem_wdata_none, mem_wdata_idx}),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb - free_index_stack_allocator testbench
// Drives allocate, release, clear and rebuild requests through the start/busy
// port and writes pool_size on the configuration channel between phases. A
// predictor keeps its own next-link memory, head and free counter, and every
// response strobe is checked field by field against the oldest prediction.
// Directed tests cover the reset chain, empty list, range checks, pool size
// extremes, double release and both free counter limits; random phases follow.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LIST_DEPTH = 1024;
    localparam logic [15:0] LINK_NONE  = 16'hFFFF;

    logic           i_clk;
    logic           i_rst_n   = 1'b0;
    logic           start     = 1'b0;
    logic           busy;
    fisa_pkg::t_req req_in    = '0;
    logic           o_valid;
    fisa_pkg::t_rsp rsp_out;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [10:0]    cfg_data  = '0;

    free_index_stack_allocator #(
        .MAX_ENTRIES (LIST_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (req_in),
        .o_valid     (o_valid),
        .o_rsp       (rsp_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // free list predictor state
    logic [15:0] link_mem [LIST_DEPTH];
    logic [15:0] head_idx;
    logic [10:0] free_cnt;
    logic [10:0] pool_reg;

    fisa_pkg::t_rsp rsp_due_q [$];
    logic [9:0]     held_q [$];

    int unsigned err_cnt     = 0;
    int unsigned n_sent      = 0;
    int unsigned n_checked   = 0;
    int unsigned n_rebuild   = 0;
    int unsigned n_empty     = 0;
    int unsigned n_range     = 0;
    int unsigned n_pool_sets = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("FAIL free_index_stack_allocator");
        $finish;
    end

    function automatic logic [10:0] live_size();
        if (pool_reg > LIST_DEPTH) begin
            return 11'(LIST_DEPTH);
        end
        return pool_reg;
    endfunction

    function automatic void rechain_free_list();
        logic [10:0] n;
        n = live_size();
        for (int i = 0; i < LIST_DEPTH; i++) begin
            link_mem[i] = (i + 1 < n) ? 16'(i + 1) : LINK_NONE;
        end
        head_idx = (n > 0) ? 16'd0 : LINK_NONE;
        free_cnt = n;
    endfunction

    function automatic fisa_pkg::t_rsp apply_to_free_list(input fisa_pkg::t_req req);
        fisa_pkg::t_rsp r;
        logic [10:0]    n;
        n = live_size();
        r = '0;
        case (req.action)
            fisa_pkg::ACT_ALLOC: begin
                if (head_idx == LINK_NONE || head_idx >= LIST_DEPTH) begin
                    head_idx = LINK_NONE;
                    r.status = fisa_pkg::ST_EMPTY;
                end else begin
                    r.granted_index = head_idx[9:0];
                    head_idx = link_mem[head_idx[9:0]];
                    if (free_cnt != 0) free_cnt = free_cnt - 11'd1;
                end
            end
            fisa_pkg::ACT_RELEASE: begin
                if ({1'b0, req.release_index} >= n) begin
                    r.status = fisa_pkg::ST_RANGE;
                end else begin
                    link_mem[req.release_index] = head_idx;
                    head_idx = {6'd0, req.release_index};
                    if (free_cnt != fisa_pkg::COUNT_MAX) free_cnt = free_cnt + 11'd1;
                end
            end
            fisa_pkg::ACT_CLEAR: begin
                head_idx = LINK_NONE;
                free_cnt = '0;
            end
            default: begin
                rechain_free_list();
            end
        endcase
        r.list_empty = (head_idx == LINK_NONE);
        r.used_count = (n > free_cnt) ? n - free_cnt : 11'd0;
        return r;
    endfunction

    always @(posedge i_clk) begin : check_rsp
        fisa_pkg::t_rsp want;
        if (i_rst_n && o_valid) begin
            if (rsp_due_q.size() == 0) begin
                $error("response with no request outstanding");
                err_cnt++;
            end else begin
                want = rsp_due_q.pop_front();
                n_checked++;
                if (rsp_out.granted_index !== want.granted_index) begin
                    $error("granted_index: expected %0d, got %0d",
                           want.granted_index, rsp_out.granted_index);
                    err_cnt++;
                end
                if (rsp_out.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_out.status);
                    err_cnt++;
                end
                if (rsp_out.list_empty !== want.list_empty) begin
                    $error("list_empty: expected %0d, got %0d",
                           want.list_empty, rsp_out.list_empty);
                    err_cnt++;
                end
                if (rsp_out.used_count !== want.used_count) begin
                    $error("used_count: expected %0d, got %0d",
                           want.used_count, rsp_out.used_count);
                    err_cnt++;
                end
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_request(input logic [1:0] act, input logic [9:0] idx,
                                input int unsigned gap);
        fisa_pkg::t_req req;
        fisa_pkg::t_rsp want;
        req.action        = act;
        req.release_index = idx;
        if (!start) start <= 1'b1;
        req_in <= req;
        do @(posedge i_clk); while (busy);
        want = apply_to_free_list(req);
        rsp_due_q.push_back(want);
        n_sent++;
        if (want.status == fisa_pkg::ST_EMPTY) n_empty++;
        if (want.status == fisa_pkg::ST_RANGE) n_range++;
        case (act)
            fisa_pkg::ACT_ALLOC: begin
                if (want.status == fisa_pkg::ST_OK) held_q.push_back(want.granted_index);
            end
            fisa_pkg::ACT_CLEAR: begin
                held_q.delete();
                for (int i = 0; i < live_size(); i++) held_q.push_back(10'(i));
            end
            fisa_pkg::ACT_REBUILD: begin
                held_q.delete();
                n_rebuild++;
            end
            default: ;
        endcase
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_quiet();
        if (start) start <= 1'b0;
        do @(posedge i_clk); while (rsp_due_q.size() != 0 || busy);
    endtask

    task automatic write_pool_size(input logic [10:0] value);
        wait_for_quiet();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        pool_reg = value;
        n_pool_sets++;
    endtask

    task automatic test_reset_chain();
        send_request(fisa_pkg::ACT_ALLOC, 10'd0, 0);
        send_request(fisa_pkg::ACT_ALLOC, 10'd0, 0);
        send_request(fisa_pkg::ACT_ALLOC, 10'd0, 1);
        send_request(fisa_pkg::ACT_RELEASE, 10'd1, 0);
        send_request(fisa_pkg::ACT_ALLOC, 10'h3FF, 2);
    endtask

    task automatic test_clear_and_empty();
        send_request(fisa_pkg::ACT_CLEAR, 10'h2AA, 0);
        send_request(fisa_pkg::ACT_ALLOC, 10'd0, 2);
        send_request(fisa_pkg::ACT_RELEASE, 10'd1023, 0);
        send_request(fisa_pkg::ACT_RELEASE, 10'd0, 0);
        send_request(fisa_pkg::ACT_ALLOC, 10'h155, 0);
        send_request(fisa_pkg::ACT_ALLOC, 10'd0, 0);
        send_request(fisa_pkg::ACT_ALLOC, 10'd0, 0);
    endtask

    task automatic test_pool_limits();
        write_pool_size(11'd4);
        send_request(fisa_pkg::ACT_RELEASE, 10'd4, 0);
        send_request(fisa_pkg::ACT_RELEASE, 10'd3, 0);
        send_request(fisa_pkg::ACT_ALLOC, 10'd0, 1);
        write_pool_size(11'd0);
        send_request(fisa_pkg::ACT_RELEASE, 10'd0, 0);
        send_request(fisa_pkg::ACT_REBUILD, 10'd0, 0);
        send_request(fisa_pkg::ACT_ALLOC, 10'd0, 0);
        write_pool_size(11'd2047);
        send_request(fisa_pkg::ACT_REBUILD, 10'd0, 0);
        send_request(fisa_pkg::ACT_RELEASE, 10'd1023, 0);
        send_request(fisa_pkg::ACT_ALLOC, 10'd0, 0);
        write_pool_size(11'd1);
        send_request(fisa_pkg::ACT_REBUILD, 10'h3FF, 0);
        send_request(fisa_pkg::ACT_ALLOC, 10'd0, 0);
        send_request(fisa_pkg::ACT_ALLOC, 10'd0, 0);
        send_request(fisa_pkg::ACT_RELEASE, 10'd1, 0);
    endtask

    task automatic test_double_release();
        write_pool_size(11'd8);
        send_request(fisa_pkg::ACT_REBUILD, 10'd0, 0);
        send_request(fisa_pkg::ACT_CLEAR, 10'd0, 0);
        send_request(fisa_pkg::ACT_RELEASE, 10'd3, 0);
        send_request(fisa_pkg::ACT_RELEASE, 10'd3, 1);
        repeat (4) send_request(fisa_pkg::ACT_ALLOC, 10'd0, 0);
        send_request(fisa_pkg::ACT_CLEAR, 10'd0, 0);
    endtask

    task automatic test_count_ceiling();
        write_pool_size(fisa_pkg::POOL_RESET);
        send_request(fisa_pkg::ACT_REBUILD, 10'd0, 0);
        repeat (1030) send_request(fisa_pkg::ACT_RELEASE, 10'd7, 0);
        send_request(fisa_pkg::ACT_ALLOC, 10'd0, 0);
        send_request(fisa_pkg::ACT_CLEAR, 10'd0, 0);
    endtask

    task automatic test_random_traffic(input logic [10:0] pool, input int unsigned count);
        int unsigned k;
        int unsigned roll;
        int unsigned calm;
        int unsigned gap;
        int unsigned pos;
        logic [9:0]  idx;
        logic [10:0] n;
        calm = 0;
        write_pool_size(pool);
        send_request(fisa_pkg::ACT_REBUILD, 10'($urandom), pick_gap());
        for (k = 0; k < count; k++) begin
            if (k == count / 2) begin
                write_pool_size((pool == 0) ? 11'd1 : pool - 11'd1);
            end else if ($urandom_range(0, 99) == 0) begin
                wait_for_quiet();
            end
            if (calm != 0) begin
                calm--;
                gap = 0;
            end else begin
                gap = pick_gap();
                if ($urandom_range(0, 49) == 0) calm = $urandom_range(30, 80);
            end
            n    = live_size();
            idx  = 10'($urandom);
            roll = $urandom_range(0, 99);
            if (roll < 44) begin
                send_request(fisa_pkg::ACT_ALLOC, idx, gap);
            end else if (roll < 80 && held_q.size() != 0) begin
                pos = $urandom_range(0, held_q.size() - 1);
                idx = held_q[pos];
                held_q.delete(pos);
                send_request(fisa_pkg::ACT_RELEASE, idx, gap);
            end else if (roll < 89) begin
                if (roll >= 86 && n < LIST_DEPTH) idx = 10'($urandom_range(n, LIST_DEPTH - 1));
                send_request(fisa_pkg::ACT_RELEASE, idx, gap);
            end else if (roll < 96) begin
                send_request(fisa_pkg::ACT_CLEAR, idx, gap);
            end else begin
                send_request(fisa_pkg::ACT_REBUILD, idx, gap);
            end
        end
    endtask

    initial begin : main
        int unsigned waited;
        pool_reg = fisa_pkg::POOL_RESET;
        rechain_free_list();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_chain();
        test_clear_and_empty();
        test_pool_limits();
        test_double_release();
        test_count_ceiling();

        test_random_traffic(11'd16, 90);
        test_random_traffic(fisa_pkg::POOL_RESET, 90);
        test_random_traffic(11'd2047, 90);
        test_random_traffic(11'd3, 90);
        test_random_traffic(11'($urandom_range(5, 200)), 90);
        test_random_traffic(11'd1, 90);

        if (start) start <= 1'b0;
        waited = 0;
        while (rsp_due_q.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (rsp_due_q.size() != 0) begin
            $error("%0d responses never arrived", rsp_due_q.size());
            err_cnt++;
        end

        $display("Covered %0d requests over %0d pool settings:", n_sent, n_pool_sets);
        $display("  %0d rebuilds, %0d empty allocates, %0d out-of-range releases.",
                 n_rebuild, n_empty, n_range);
        $display("Checked %0d responses, %0d mismatches.", n_checked, err_cnt);
        if (err_cnt == 0) begin
            $display("PASS free_index_stack_allocator");
        end else begin
            $display("FAIL free_index_stack_allocator");
        end
        $finish;
    end

endmodule

[files.f]
rtl/fisa_pkg.sv
rtl/fisa_ram.sv
rtl/fisa_ctrl.sv
rtl/free_index_stack_allocator.sv
bench/tb.sv
